[design/tsg_pkg.sv]
// ---------------------------------------------------------------------------
// Turtle segment generator package
// Shared types, symbol codes, status codes and sizes for the turtle core.
// ---------------------------------------------------------------------------
package tsg_pkg;

   // Stack size and the width of the saved-entry count
   localparam int STACK_DEPTH = 16;
   localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);

   // Fixed widths of the datapath
   localparam int POS_W  = 32;
   localparam int HEAD_W = 18;
   localparam int TRIG_W = 18;

   // Command symbols
   localparam logic [7:0] SYM_LEFT  = 8'h2B;
   localparam logic [7:0] SYM_RIGHT = 8'h2D;
   localparam logic [7:0] SYM_PUSH  = 8'h5B;
   localparam logic [7:0] SYM_POP   = 8'h5D;

   // Result status codes
   localparam logic [1:0] STATUS_SEGMENT   = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   // Register indexes
   localparam logic CSR_COS = 1'b0;
   localparam logic CSR_SIN = 1'b1;

   // Register reset values and the unit heading
   localparam logic signed [TRIG_W-1:0] COS_RESET = 18'sd56756;
   localparam logic signed [TRIG_W-1:0] SIN_RESET = 18'sd32768;
   localparam logic signed [HEAD_W-1:0] UNIT      = 18'sd65536;

   // One saved turtle state
   typedef struct packed {
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [HEAD_W-1:0] head_x;
      logic signed [HEAD_W-1:0] head_y;
   } entry_type;

   // Stack shift control shared by all cells
   typedef struct packed {
      logic push;
      logic pop;
   } shift_type;

endpackage

[design/tsg_channels.sv]
// ---------------------------------------------------------------------------
// Turtle segment generator channels
// Valid/ready channel interfaces for symbols, segments and register writes.
// ---------------------------------------------------------------------------

// Symbol channel
interface tsg_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       first_of_string;

   modport source (output valid, output symbol, output first_of_string, input ready);
   modport sink   (input valid, input symbol, input first_of_string, output ready);
endinterface

// Segment result channel
interface tsg_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [31:0] start_x;
   logic signed [31:0] start_y;
   logic signed [31:0] end_x;
   logic signed [31:0] end_y;

   modport source (output valid, output status, output start_x, output start_y,
                   output end_x, output end_y, input ready);
   modport sink   (input valid, input status, input start_x, input start_y,
                   input end_x, input end_y, output ready);
endinterface

// Register write channel
interface tsg_csr_if;
   logic               valid;
   logic               ready;
   logic               reg_index;
   logic signed [17:0] write_data;

   modport source (output valid, output reg_index, output write_data, input ready);
   modport sink   (input valid, input reg_index, input write_data, output ready);
endinterface

[design/tsg_stack_cell.sv]
// ---------------------------------------------------------------------------
// Turtle stack cell
// One entry of the shifting state stack; takes the entry above on a push
// and the entry below on a pop.
// ---------------------------------------------------------------------------
module tsg_stack_cell (
   input  logic               clock,
   input  tsg_pkg::shift_type shift,
   input  tsg_pkg::entry_type from_above,
   input  tsg_pkg::entry_type from_below,
   output tsg_pkg::entry_type entry
);

   tsg_pkg::entry_type entry_ff;
   tsg_pkg::entry_type entry_in;

   // Select the neighbor to load
   always_comb begin
      entry_in = entry_ff;
      if (shift.push) begin
         entry_in = from_above;
      end else if (shift.pop) begin
         entry_in = from_below;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

[design/tsg_heading_rotator.sv]
// ---------------------------------------------------------------------------
// Turtle heading rotator
// Rotates the heading by the turn angle, shifts by 16 and clamps to unit.
// ---------------------------------------------------------------------------
module tsg_heading_rotator (
   input  logic signed [tsg_pkg::HEAD_W-1:0] head_x,
   input  logic signed [tsg_pkg::HEAD_W-1:0] head_y,
   input  logic signed [tsg_pkg::TRIG_W-1:0] cos_turn,
   input  logic signed [tsg_pkg::TRIG_W-1:0] sin_turn,
   input  logic                              turn_left,
   output logic signed [tsg_pkg::HEAD_W-1:0] rot_x,
   output logic signed [tsg_pkg::HEAD_W-1:0] rot_y
);

   localparam int PROD_W = tsg_pkg::HEAD_W + tsg_pkg::TRIG_W;
   localparam int SUM_W  = PROD_W + 1;
   localparam int SHR_W  = SUM_W - 16;

   logic signed [PROD_W-1:0] xc, xs, yc, ys;
   logic signed [SUM_W-1:0]  sum_x, sum_y;

   // Clamp the shifted sum to [-unit, unit]
   function automatic logic signed [tsg_pkg::HEAD_W-1:0] clamp_unit(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [SHR_W-1:0] shr;
      shr = v[SUM_W-1:16];
      if (shr > SHR_W'(tsg_pkg::UNIT)) begin
         return tsg_pkg::UNIT;
      end else if (shr < -SHR_W'(tsg_pkg::UNIT)) begin
         return -tsg_pkg::UNIT;
      end
      return shr[tsg_pkg::HEAD_W-1:0];
   endfunction

   // Four products
   assign xc = PROD_W'(head_x) * PROD_W'(cos_turn);
   assign xs = PROD_W'(head_x) * PROD_W'(sin_turn);
   assign yc = PROD_W'(head_y) * PROD_W'(cos_turn);
   assign ys = PROD_W'(head_y) * PROD_W'(sin_turn);

   // Counter-clockwise or clockwise combination
   always_comb begin
      if (turn_left) begin
         sum_x = SUM_W'(xc) - SUM_W'(ys);
         sum_y = SUM_W'(xs) + SUM_W'(yc);
      end else begin
         sum_x = SUM_W'(xc) + SUM_W'(ys);
         sum_y = SUM_W'(yc) - SUM_W'(xs);
      end
   end

   assign rot_x = clamp_unit(sum_x);
   assign rot_y = clamp_unit(sum_y);

endmodule

[design/turtle_segment_generator_core.sv]
// ---------------------------------------------------------------------------
// Turtle segment generator core
// Interprets a stream of L-system symbols and emits line segments.
// ---------------------------------------------------------------------------
// Usage:
//   req_ch carries one symbol per transaction with a first_of_string flag
//   that restarts the turtle at the origin, heading up, with an empty stack.
//   rsp_ch carries a segment, or a stack overflow/underflow error, for each
//   drawing symbol or failed push/pop. Turns and good push/pop give nothing.
//   csr_ch writes the turn cosine (index 0) and sine (index 1) and is always
//   ready; it is to be written only while the core is idle, which the core does not enforce.
// Timing:
//   One symbol per cycle while rsp_ch takes each result. A result is registered
//   and appears on rsp_ch in the cycle after its symbol is accepted. The turtle
//   state loop (rotation multiply, position add and saturate) is combinational;
//   the saved states sit in a chain of stack cells that shift together on push and pop.
// Reset and stall:
//   Reset restores the registers, puts the turtle at the origin heading up
//   and empties the stack. A held result keeps req_ch ready only in the
//   cycle in which rsp_ch takes it; otherwise symbol intake waits.
// ---------------------------------------------------------------------------
module turtle_segment_generator_core (
   input  logic           clock,
   input  logic           reset,
   tsg_req_if.sink        req_ch,
   tsg_rsp_if.source      rsp_ch,
   tsg_csr_if.sink        csr_ch
);

   localparam int DEPTH = tsg_pkg::STACK_DEPTH;
   localparam int LW    = tsg_pkg::LEVEL_W;
   localparam int PW    = tsg_pkg::POS_W;
   localparam int HW    = tsg_pkg::HEAD_W;

   // Turtle state and registers
   logic signed [PW-1:0]              pos_x_ff, pos_x_in;
   logic signed [PW-1:0]              pos_y_ff, pos_y_in;
   logic signed [HW-1:0]              head_x_ff, head_x_in;
   logic signed [HW-1:0]              head_y_ff, head_y_in;
   logic [LW-1:0]                     level_ff, level_in;
   logic signed [tsg_pkg::TRIG_W-1:0] cos_ff, sin_ff;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           status_ff, status_in;
   logic signed [PW-1:0] start_x_ff, start_x_in;
   logic signed [PW-1:0] start_y_ff, start_y_in;
   logic signed [PW-1:0] end_x_ff, end_x_in;
   logic signed [PW-1:0] end_y_ff, end_y_in;

   // Working values
   logic                 req_fire;
   logic signed [PW-1:0] cur_x, cur_y;
   logic signed [HW-1:0] cur_hx, cur_hy;
   logic [LW-1:0]        cur_level;
   logic signed [HW-1:0] rot_x, rot_y;
   logic signed [PW-1:0] seg_x, seg_y;
   logic signed [PW:0]   sum_x, sum_y;
   tsg_pkg::shift_type   shift;
   tsg_pkg::entry_type   cur_entry;
   tsg_pkg::entry_type   cells [DEPTH];

   assign req_fire     = req_ch.valid & req_ch.ready;
   assign req_ch.ready = ~rsp_valid_ff | rsp_ch.ready;
   assign csr_ch.ready = 1'b1;

   // State seen by this symbol, after an optional restart
   always_comb begin
      if (req_ch.first_of_string) begin
         cur_x     = '0;
         cur_y     = '0;
         cur_hx    = '0;
         cur_hy    = tsg_pkg::UNIT;
         cur_level = '0;
      end else begin
         cur_x     = pos_x_ff;
         cur_y     = pos_y_ff;
         cur_hx    = head_x_ff;
         cur_hy    = head_y_ff;
         cur_level = level_ff;
      end
   end

   assign cur_entry = '{pos_x: cur_x, pos_y: cur_y, head_x: cur_hx, head_y: cur_hy};

   // Heading rotation
   tsg_heading_rotator u_rotator (
      .head_x    (cur_hx),
      .head_y    (cur_hy),
      .cos_turn  (cos_ff),
      .sin_turn  (sin_ff),
      .turn_left (req_ch.symbol == tsg_pkg::SYM_LEFT),
      .rot_x     (rot_x),
      .rot_y     (rot_y)
   );

   // Segment end with saturation
   assign sum_x = (PW+1)'(cur_x) + (PW+1)'(cur_hx);
   assign sum_y = (PW+1)'(cur_y) + (PW+1)'(cur_hy);

   always_comb begin
      seg_x = sum_x[PW-1:0];
      if (sum_x[PW] != sum_x[PW-1]) begin
         seg_x = sum_x[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end
      seg_y = sum_y[PW-1:0];
      if (sum_y[PW] != sum_y[PW-1]) begin
         seg_y = sum_y[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
      end
   end

   // Symbol decode and next state
   always_comb begin
      pos_x_in     = pos_x_ff;
      pos_y_in     = pos_y_ff;
      head_x_in    = head_x_ff;
      head_y_in    = head_y_ff;
      level_in     = level_ff;
      shift        = '0;
      rsp_valid_in = rsp_valid_ff & ~rsp_ch.ready;
      status_in    = status_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      end_x_in     = end_x_ff;
      end_y_in     = end_y_ff;
      if (req_fire) begin
         pos_x_in  = cur_x;
         pos_y_in  = cur_y;
         head_x_in = cur_hx;
         head_y_in = cur_hy;
         level_in  = cur_level;
         unique case (req_ch.symbol) inside
            tsg_pkg::SYM_LEFT, tsg_pkg::SYM_RIGHT: begin
               head_x_in = rot_x;
               head_y_in = rot_y;
            end
            tsg_pkg::SYM_PUSH: begin
               if (cur_level == LW'(DEPTH)) begin
                  rsp_valid_in = 1'b1;
                  status_in    = tsg_pkg::STATUS_OVERFLOW;
                  start_x_in   = '0;
                  start_y_in   = '0;
                  end_x_in     = '0;
                  end_y_in     = '0;
               end else begin
                  shift.push = 1'b1;
                  level_in   = cur_level + 1'b1;
               end
            end
            tsg_pkg::SYM_POP: begin
               if (cur_level == '0) begin
                  rsp_valid_in = 1'b1;
                  status_in    = tsg_pkg::STATUS_UNDERFLOW;
                  start_x_in   = '0;
                  start_y_in   = '0;
                  end_x_in     = '0;
                  end_y_in     = '0;
               end else begin
                  shift.pop = 1'b1;
                  level_in  = cur_level - 1'b1;
                  pos_x_in  = cells[0].pos_x;
                  pos_y_in  = cells[0].pos_y;
                  head_x_in = cells[0].head_x;
                  head_y_in = cells[0].head_y;
               end
            end
            default: begin
               rsp_valid_in = 1'b1;
               status_in    = tsg_pkg::STATUS_SEGMENT;
               start_x_in   = cur_x;
               start_y_in   = cur_y;
               end_x_in     = seg_x;
               end_y_in     = seg_y;
               pos_x_in     = seg_x;
               pos_y_in     = seg_y;
            end
         endcase
      end
   end

   // Chain of stack cells, top of stack at cell 0
   for (genvar i = 0; i < DEPTH; i++) begin : g_stack
      tsg_pkg::entry_type above, below;
      if (i == 0) begin : g_top
         assign above = cur_entry;
      end else begin : g_mid
         assign above = cells[i-1];
      end
      if (i == DEPTH - 1) begin : g_end
         assign below = cells[i];
      end else begin : g_inner
         assign below = cells[i+1];
      end
      tsg_stack_cell u_cell (
         .clock      (clock),
         .shift      (shift),
         .from_above (above),
         .from_below (below),
         .entry      (cells[i])
      );
   end

   // Control state and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         head_x_ff    <= '0;
         head_y_ff    <= tsg_pkg::UNIT;
         level_ff     <= '0;
         cos_ff       <= tsg_pkg::COS_RESET;
         sin_ff       <= tsg_pkg::SIN_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         head_x_ff    <= head_x_in;
         head_y_ff    <= head_y_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_ch.valid) begin
            if (csr_ch.reg_index == tsg_pkg::CSR_COS) begin
               cos_ff <= csr_ch.write_data;
            end else begin
               sin_ff <= csr_ch.write_data;
            end
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      start_x_ff <= start_x_in;
      start_y_ff <= start_y_in;
      end_x_ff   <= end_x_in;
      end_y_ff   <= end_y_in;
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.status  = status_ff;
   assign rsp_ch.start_x = start_x_ff;
   assign rsp_ch.start_y = start_y_ff;
   assign rsp_ch.end_x   = end_x_ff;
   assign rsp_ch.end_y   = end_y_ff;

endmodule

[test/turtle_segment_generator_core_test.sv]
// ---------------------------------------------------------------------------
// Turtle segment generator core testbench
// Streams L-system symbols into the core under random source and sink
// stalls, predicts every segment and stack error from its own turtle model,
// and compares each result transaction field by field. Covers reset state,
// field extremes, stack bounds, extreme turn settings, random strings and
// an unbroken stream at the end.
// ---------------------------------------------------------------------------
module turtle_segment_generator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles to let the core settle after the last expected result
   localparam int DRAIN_CYCLES = 4;
   localparam int RANDOM_SYMBOLS = 900;
   localparam int TAIL_DRAWS = 20;
   localparam longint HEAD_LIMIT = 65536;
   localparam longint POS_MAX = 64'sd2147483647;
   localparam longint POS_MIN = -64'sd2147483648;
   // Plain drawing symbol used by most strings
   localparam logic [7:0] DRAW_F = 8'h46;

   typedef struct {
      logic [1:0]                       status;
      logic signed [tsg_pkg::POS_W-1:0] start_x;
      logic signed [tsg_pkg::POS_W-1:0] start_y;
      logic signed [tsg_pkg::POS_W-1:0] end_x;
      logic signed [tsg_pkg::POS_W-1:0] end_y;
   } segment_type;

   logic clock;
   logic reset;

   tsg_req_if req_ch ();
   tsg_rsp_if rsp_ch ();
   tsg_csr_if csr_ch ();

   turtle_segment_generator_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Turtle state as the core should hold it
   logic signed [tsg_pkg::POS_W-1:0]  turtle_x;
   logic signed [tsg_pkg::POS_W-1:0]  turtle_y;
   logic signed [tsg_pkg::HEAD_W-1:0] heading_x;
   logic signed [tsg_pkg::HEAD_W-1:0] heading_y;
   logic signed [tsg_pkg::POS_W-1:0]  saved_x  [tsg_pkg::STACK_DEPTH];
   logic signed [tsg_pkg::POS_W-1:0]  saved_y  [tsg_pkg::STACK_DEPTH];
   logic signed [tsg_pkg::HEAD_W-1:0] saved_hx [tsg_pkg::STACK_DEPTH];
   logic signed [tsg_pkg::HEAD_W-1:0] saved_hy [tsg_pkg::STACK_DEPTH];
   int unsigned                       saved_count;
   logic signed [tsg_pkg::TRIG_W-1:0] turn_cos;
   logic signed [tsg_pkg::TRIG_W-1:0] turn_sin;

   segment_type pending_segments[$];
   segment_type next_segment;
   int          mismatch_count = 0;

   // Idle control, percent chance of a burst per transaction or cycle
   int send_idle_pct = 15;
   int take_idle_pct = 15;
   int take_stall_left = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void restart_turtle();
      turtle_x    = '0;
      turtle_y    = '0;
      heading_x   = '0;
      heading_y   = tsg_pkg::UNIT;
      saved_count = 0;
   endfunction

   function automatic logic signed [tsg_pkg::HEAD_W-1:0] clamp_heading(longint v);
      if (v > HEAD_LIMIT) return tsg_pkg::UNIT;
      if (v < -HEAD_LIMIT) return -tsg_pkg::UNIT;
      return v[tsg_pkg::HEAD_W-1:0];
   endfunction

   function automatic logic signed [tsg_pkg::POS_W-1:0] saturate_pos(longint v);
      if (v > POS_MAX) return POS_MAX[tsg_pkg::POS_W-1:0];
      if (v < POS_MIN) return POS_MIN[tsg_pkg::POS_W-1:0];
      return v[tsg_pkg::POS_W-1:0];
   endfunction

   // Append one predicted result behind the others
   function automatic void queue_result(segment_type seg);
      pending_segments = {pending_segments, seg};
   endfunction

   // Advance the turtle by one symbol and queue the result it causes
   function automatic void interpret_symbol(logic [7:0] sym, logic first);
      longint      hx, hy, c, s;
      segment_type seg;
      if (first) restart_turtle();
      hx = heading_x;
      hy = heading_y;
      c  = turn_cos;
      s  = turn_sin;
      seg.status  = tsg_pkg::STATUS_SEGMENT;
      seg.start_x = '0;
      seg.start_y = '0;
      seg.end_x   = '0;
      seg.end_y   = '0;
      case (sym)
         tsg_pkg::SYM_LEFT: begin
            heading_x = clamp_heading((hx * c - hy * s) >>> 16);
            heading_y = clamp_heading((hx * s + hy * c) >>> 16);
         end
         tsg_pkg::SYM_RIGHT: begin
            heading_x = clamp_heading((hx * c + hy * s) >>> 16);
            heading_y = clamp_heading((hy * c - hx * s) >>> 16);
         end
         tsg_pkg::SYM_PUSH: begin
            if (saved_count >= tsg_pkg::STACK_DEPTH) begin
               seg.status = tsg_pkg::STATUS_OVERFLOW;
               queue_result(seg);
            end else begin
               saved_x[saved_count]  = turtle_x;
               saved_y[saved_count]  = turtle_y;
               saved_hx[saved_count] = heading_x;
               saved_hy[saved_count] = heading_y;
               saved_count++;
            end
         end
         tsg_pkg::SYM_POP: begin
            if (saved_count == 0) begin
               seg.status = tsg_pkg::STATUS_UNDERFLOW;
               queue_result(seg);
            end else begin
               saved_count--;
               turtle_x  = saved_x[saved_count];
               turtle_y  = saved_y[saved_count];
               heading_x = saved_hx[saved_count];
               heading_y = saved_hy[saved_count];
            end
         end
         default: begin
            seg.start_x = turtle_x;
            seg.start_y = turtle_y;
            seg.end_x   = saturate_pos(longint'(turtle_x) + hx);
            seg.end_y   = saturate_pos(longint'(turtle_y) + hy);
            turtle_x    = seg.end_x;
            turtle_y    = seg.end_y;
            queue_result(seg);
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------------
   function automatic void note_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch %0d: %s", mismatch_count, msg);
   endfunction

   function automatic void check_field(string field, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (want !== got)
         note_mismatch($sformatf("%s expected %0d got %0d", field, want, got));
   endfunction

   // Compare each accepted result transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_segments.size() == 0) begin
            note_mismatch($sformatf("result with none pending, status %0d", rsp_ch.status));
         end else begin
            next_segment = pending_segments.pop_front();
            check_field("status", next_segment.status, rsp_ch.status);
            check_field("start_x", next_segment.start_x, rsp_ch.start_x);
            check_field("start_y", next_segment.start_y, rsp_ch.start_y);
            check_field("end_x", next_segment.end_x, rsp_ch.end_x);
            check_field("end_y", next_segment.end_y, rsp_ch.end_y);
         end
      end
   end

   // Result sink with random stall bursts
   always @(posedge clock) begin
      if (take_stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         take_stall_left--;
      end else if (take_idle_pct > 0 && $urandom_range(0, 99) < take_idle_pct) begin
         rsp_ch.ready <= 1'b0;
         take_stall_left = $urandom_range(1, 13) - 1;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------------
   // One symbol transaction, with an optional idle burst ahead of it
   task automatic send_symbol(logic [7:0] sym, logic first);
      int gap;
      gap = 0;
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct)
         gap = $urandom_range(1, 13);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid           <= 1'b1;
      req_ch.symbol          <= sym;
      req_ch.first_of_string <= first;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      interpret_symbol(sym, first);
   endtask

   // Stop sending and let every pending result come out
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_segments.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write both turn registers back to back while the core is idle
   task automatic set_turn_angle(logic signed [tsg_pkg::TRIG_W-1:0] c,
                                 logic signed [tsg_pkg::TRIG_W-1:0] s);
      wait_for_drain();
      csr_ch.valid      <= 1'b1;
      csr_ch.reg_index  <= tsg_pkg::CSR_COS;
      csr_ch.write_data <= c;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      turn_cos = c;
      csr_ch.reg_index  <= tsg_pkg::CSR_SIN;
      csr_ch.write_data <= s;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      turn_sin = s;
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [7:0] pick_draw_symbol();
      logic [7:0] b;
      if ($urandom_range(0, 1) == 0) return DRAW_F;
      b = $urandom_range(0, 255);
      while (b == tsg_pkg::SYM_LEFT || b == tsg_pkg::SYM_RIGHT ||
             b == tsg_pkg::SYM_PUSH || b == tsg_pkg::SYM_POP)
         b = $urandom_range(0, 255);
      return b;
   endfunction

   // Mostly well-formed string: balanced brackets, turns and draws, with
   // occasional stray brackets, mid-string restarts and raw bytes
   task automatic send_random_string(int length);
      int          pick;
      int unsigned level;
      logic [7:0]  sym;
      logic        first;
      for (int i = 0; i < length; i++) begin
         first = (i == 0) ? 1'b1 : ($urandom_range(0, 99) < 2);
         level = first ? 0 : saved_count;
         pick  = $urandom_range(0, 99);
         if (pick < 40)
            sym = pick_draw_symbol();
         else if (pick < 55)
            sym = tsg_pkg::SYM_LEFT;
         else if (pick < 70)
            sym = tsg_pkg::SYM_RIGHT;
         else if (pick < 85)
            sym = (level < tsg_pkg::STACK_DEPTH || $urandom_range(0, 3) == 0) ?
                  tsg_pkg::SYM_PUSH : tsg_pkg::SYM_POP;
         else if (pick < 97)
            sym = (level > 0 || $urandom_range(0, 3) == 0) ?
                  tsg_pkg::SYM_POP : tsg_pkg::SYM_PUSH;
         else
            sym = $urandom_range(0, 255);
         send_symbol(sym, first);
      end
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   // Turtle must start at origin heading up with reset turn values
   task automatic test_after_reset();
      send_symbol(DRAW_F, 1'b0);
      send_symbol(tsg_pkg::SYM_LEFT, 1'b0);
      send_symbol(DRAW_F, 1'b0);
      send_symbol(tsg_pkg::SYM_RIGHT, 1'b0);
      send_symbol(tsg_pkg::SYM_RIGHT, 1'b0);
      send_symbol(DRAW_F, 1'b0);
      send_symbol(tsg_pkg::SYM_POP, 1'b0);
      send_symbol(tsg_pkg::SYM_PUSH, 1'b0);
      send_symbol(tsg_pkg::SYM_POP, 1'b0);
   endtask

   // Byte extremes, and restarts that come with draw, pop and turn symbols
   task automatic test_field_extremes();
      send_symbol(8'h00, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(tsg_pkg::SYM_PUSH, 1'b0);
      send_symbol(tsg_pkg::SYM_POP, 1'b1);
      send_symbol(tsg_pkg::SYM_RIGHT, 1'b1);
      send_symbol(8'hFF, 1'b0);
      send_symbol(tsg_pkg::SYM_LEFT, 1'b1);
      send_symbol(8'h00, 1'b0);
   endtask

   // Fill the stack, overflow once, then a restart empties it
   task automatic test_stack_bounds();
      for (int i = 0; i <= tsg_pkg::STACK_DEPTH; i++) send_symbol(tsg_pkg::SYM_PUSH, i == 0);
      send_symbol(DRAW_F, 1'b0);
      send_symbol(tsg_pkg::SYM_POP, 1'b1);
   endtask

   // Unit and out-of-range turn values; the heading clamp bounds them
   task automatic test_turn_extremes();
      logic signed [tsg_pkg::TRIG_W-1:0] cos_list [10];
      logic signed [tsg_pkg::TRIG_W-1:0] sin_list [10];
      cos_list = '{18'sd65536, -18'sd65536, 18'sd0, 18'sd0, 18'sd65536,
                   -18'sd65536, 18'sd131071, -18'sd131072, 18'sd0, 18'sd131071};
      sin_list = '{18'sd0, 18'sd0, 18'sd65536, -18'sd65536, 18'sd65536,
                   -18'sd65536, -18'sd131072, 18'sd131071, 18'sd0, 18'sd131071};
      for (int i = 0; i < 10; i++) begin
         set_turn_angle(cos_list[i], sin_list[i]);
         send_random_string(12);
      end
   endtask

   // Random strings under changing turn values and idle patterns
   task automatic test_random_strings();
      int sent;
      int length;
      int strings;
      int c;
      int s;
      sent    = 0;
      strings = 0;
      while (sent < RANDOM_SYMBOLS) begin
         if (strings % 8 == 0) begin
            if ($urandom_range(0, 9) < 7) begin
               c = int'($urandom_range(0, 131072)) - 65536;
               s = int'($urandom_range(0, 131072)) - 65536;
            end else begin
               c = $urandom;
               s = $urandom;
            end
            set_turn_angle(c[tsg_pkg::TRIG_W-1:0], s[tsg_pkg::TRIG_W-1:0]);
         end
         case ($urandom_range(0, 3))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 30;
         endcase
         case ($urandom_range(0, 3))
            0: take_idle_pct = 0;
            1: take_idle_pct = 10;
            default: take_idle_pct = 30;
         endcase
         length = $urandom_range(4, 60);
         send_random_string(length);
         sent += length;
         strings++;
      end
   endtask

   // Diagonal runs back to back with no idling on either side
   task automatic test_steady_stream();
      send_idle_pct = 0;
      take_idle_pct = 0;
      set_turn_angle(18'sd65536, 18'sd65536);
      // one right turn points up and right
      send_symbol(tsg_pkg::SYM_RIGHT, 1'b1);
      repeat (TAIL_DRAWS) send_symbol(DRAW_F, 1'b0);
      // three left turns point down and left
      send_symbol(tsg_pkg::SYM_LEFT, 1'b1);
      send_symbol(tsg_pkg::SYM_LEFT, 1'b0);
      send_symbol(tsg_pkg::SYM_LEFT, 1'b0);
      repeat (TAIL_DRAWS) send_symbol(DRAW_F, 1'b0);
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.symbol          <= '0;
      req_ch.first_of_string <= 1'b0;
      csr_ch.valid           <= 1'b0;
      csr_ch.reg_index       <= tsg_pkg::CSR_COS;
      csr_ch.write_data      <= '0;
      restart_turtle();
      turn_cos = tsg_pkg::COS_RESET;
      turn_sin = tsg_pkg::SIN_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_after_reset();
      test_field_extremes();
      test_stack_bounds();
      test_turn_extremes();
      test_random_strings();
      test_steady_stream();

      wait_for_drain();
      if (mismatch_count == 0 && pending_segments.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[turtle_segment_generator_core.f]
design/tsg_pkg.sv
design/tsg_channels.sv
design/tsg_stack_cell.sv
design/tsg_heading_rotator.sv
design/turtle_segment_generator_core.sv
test/turtle_segment_generator_core_test.sv
